FILE: src/post3d_pkg.sv
package post3d_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 66;
  localparam int SUM_W   = 68;
  localparam int DEN_W   = 66;
  localparam int QUO_W   = 33;
  localparam int TOL_W   = 16;
  localparam int AXES    = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic signed [COORD_W-1:0] probe_x;
    logic signed [COORD_W-1:0] probe_y;
    logic signed [COORD_W-1:0] probe_z;
  } in_t;

  typedef struct packed {
    logic                      on_line;
    logic signed [COORD_W-1:0] line_param;
    logic                      on_segment;
  } out_t;

  typedef struct packed {
    logic                     ovf;
    logic                     degen;
    logic                     on_deg;
    logic                     neg;
    logic signed [DIFF_W-1:0] r1x;
    logic signed [DIFF_W-1:0] r1y;
    logic signed [DIFF_W-1:0] r1z;
    logic signed [DIFF_W-1:0] r2x;
    logic signed [DIFF_W-1:0] r2y;
    logic signed [DIFF_W-1:0] r2z;
  } side_t;

endpackage

FILE: src/post3d_front.sv
module post3d_front #(
  parameter int FRAC = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [post3d_pkg::TOL_W-1:0]          tol,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  post3d_pkg::in_t                       in_data,
  output logic                                  o_valid,
  input  logic                                  o_ready,
  output logic [post3d_pkg::DEN_W+FRAC-1:0]     o_num,
  output logic [post3d_pkg::DEN_W-1:0]          o_den,
  output post3d_pkg::side_t                     o_side
);
  import post3d_pkg::*;

  localparam int NS = 5;
  localparam int NW = DEN_W + FRAC;
  localparam int XW = (NW > DEN_W + QUO_W) ? NW : DEN_W + QUO_W;

  logic [NS-1:0] v_r, v_nxt, en;

  logic signed [COORD_W-1:0] s_c [AXES];
  logic signed [COORD_W-1:0] e_c [AXES];
  logic signed [COORD_W-1:0] p_c [AXES];

  logic signed [DIFF_W-1:0] r1_r [NS][AXES];
  logic signed [DIFF_W-1:0] r2_r [NS][AXES];
  logic signed [PROD_W-1:0] m11_r [AXES];
  logic signed [PROD_W-1:0] m22_r [AXES];
  logic signed [PROD_W-1:0] m12_r [AXES];
  logic signed [SUM_W-1:0]  r1r1_r, r2r2_r, dot_r;
  logic                     degen3_r, ondeg3_r, neg3_r;
  logic                     degen4_r, ondeg4_r, neg4_r, ovf4_r;
  logic [NW-1:0]            num3_r, num4_r;
  logic [DEN_W-1:0]         den3_r, den4_r;

  logic [2*TOL_W-1:0]       eps2;
  logic [SUM_W-1:0]         absdot;

  assign s_c = '{in_data.start_x, in_data.start_y, in_data.start_z};
  assign e_c = '{in_data.end_x, in_data.end_y, in_data.end_z};
  assign p_c = '{in_data.probe_x, in_data.probe_y, in_data.probe_z};

  always_comb begin
    en[NS-1] = !v_r[NS-1] || o_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign v_nxt    = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < AXES; i++) begin
        r1_r[0][i] <= DIFF_W'(e_c[i]) - DIFF_W'(s_c[i]);
        r2_r[0][i] <= DIFF_W'(p_c[i]) - DIFF_W'(s_c[i]);
      end
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        r1_r[k] <= r1_r[k-1];
        r2_r[k] <= r2_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < AXES; i++) begin
        m11_r[i] <= r1_r[0][i] * r1_r[0][i];
        m22_r[i] <= r2_r[0][i] * r2_r[0][i];
        m12_r[i] <= r1_r[0][i] * r2_r[0][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      r1r1_r <= SUM_W'(m11_r[0]) + SUM_W'(m11_r[1]) + SUM_W'(m11_r[2]);
      r2r2_r <= SUM_W'(m22_r[0]) + SUM_W'(m22_r[1]) + SUM_W'(m22_r[2]);
      dot_r  <= SUM_W'(m12_r[0]) + SUM_W'(m12_r[1]) + SUM_W'(m12_r[2]);
    end
  end

  assign eps2   = tol * tol;
  assign absdot = dot_r[SUM_W-1] ? $unsigned(-dot_r) : $unsigned(dot_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      degen3_r <= ($unsigned(r1r1_r) < SUM_W'(eps2)) || (r1r1_r == '0);
      ondeg3_r <= $unsigned(r2r2_r) < SUM_W'(eps2);
      neg3_r   <= dot_r[SUM_W-1];
      num3_r   <= {absdot[DEN_W-1:0], {FRAC{1'b0}}};
      den3_r   <= r1r1_r[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ovf4_r   <= XW'(num3_r) >= (XW'(den3_r) << QUO_W);
      degen4_r <= degen3_r;
      ondeg4_r <= ondeg3_r;
      neg4_r   <= neg3_r;
      num4_r   <= num3_r;
      den4_r   <= den3_r;
    end
  end

  assign o_valid = v_r[NS-1];
  assign o_num   = num4_r;
  assign o_den   = den4_r;
  assign o_side  = '{ovf: ovf4_r, degen: degen4_r, on_deg: ondeg4_r, neg: neg4_r,
                     r1x: r1_r[NS-1][0], r1y: r1_r[NS-1][1], r1z: r1_r[NS-1][2],
                     r2x: r2_r[NS-1][0], r2y: r2_r[NS-1][1], r2z: r2_r[NS-1][2]};

endmodule

FILE: src/post3d_div.sv
module post3d_div #(
  parameter int NW = 82,
  parameter int DW = 66,
  parameter int QW = 33,
  parameter int SW = 202
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          i_valid,
  output logic          i_ready,
  input  logic [NW-1:0] i_num,
  input  logic [DW-1:0] i_den,
  input  logic [SW-1:0] i_side,
  output logic          o_valid,
  input  logic          o_ready,
  output logic [QW-1:0] o_quo,
  output logic [SW-1:0] o_side
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW-1:0] v_r, en;
  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  assign en[QW-1] = !v_r[QW-1] || o_ready;
  assign i_ready  = en[0];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic [XW-1:0] sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = i_valid;
      assign rem_in  = i_num;
      assign den_in  = i_den;
      assign quo_in  = '0;
      assign side_in = i_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
    end

    if (k < QW - 1) begin : g_en
      assign en[k] = !v_r[k] || en[k+1];
    end

    assign sub = XW'(den_in) << (QW - 1 - k);
    assign ge  = XW'(rem_in) >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= ge ? rem_in - sub[NW-1:0] : rem_in;
        den_r[k]  <= den_in;
        quo_r[k]  <= {quo_in[QW-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign o_valid = v_r[QW-1];
  assign o_quo   = quo_r[QW-1];
  assign o_side  = side_r[QW-1];

endmodule

FILE: src/post3d_back.sv
module post3d_back #(
  parameter int FRAC = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [post3d_pkg::TOL_W-1:0]   tol,
  input  logic                           i_valid,
  output logic                           i_ready,
  input  logic [post3d_pkg::QUO_W-1:0]   i_quo,
  input  post3d_pkg::side_t              i_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output post3d_pkg::out_t               out_data
);
  import post3d_pkg::*;

  localparam int NS  = 6;
  localparam int DFW = PROD_W + FRAC;
  localparam int EW  = TOL_W + FRAC;
  localparam int HW  = (EW + 1) / 2;
  localparam int UW  = EW - HW;
  localparam int AW  = 2 * EW + 2;
  localparam int BW  = COORD_W + 2;
  localparam logic [BW-1:0] ONE = BW'(1) << FRAC;
  localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic [NS-1:0] v_r, v_nxt, en;

  logic signed [COORD_W-1:0] t_r [NS-1];
  logic                      degen_r [NS-1];
  logic                      ondeg_r [NS-1];
  logic signed [DIFF_W-1:0]  r1_r [AXES];
  logic signed [DIFF_W-1:0]  r2_r [2][AXES];
  logic signed [DIFF_W-1:0]  r1_in [AXES];
  logic signed [DIFF_W-1:0]  r2_in [AXES];
  logic signed [DIFF_W+COORD_W-1:0] pr_r [AXES];
  logic [EW-1:0]             ad_r [AXES];
  logic                      big_r [3];
  logic [2*HW-1:0]           ll_r [AXES];
  logic [HW+UW-1:0]          lh_r [AXES];
  logic [2*UW-1:0]           hh_r [AXES];
  logic [AW-1:0]             acc_r;
  logic                      on_line_r, on_seg_r;
  logic signed [COORD_W-1:0] line_param_r;

  logic signed [COORD_W-1:0] t_nxt;
  logic signed [DFW-1:0]     d_c  [AXES];
  logic [DFW-1:0]            ad_c [AXES];
  logic [DFW-1:0]            et;
  logic [2*EW-1:0]           sq_c [AXES];
  logic [2*TOL_W-1:0]        tsq;
  logic                      on_nd_c, on_line_nxt;
  logic signed [BW-1:0]      tw, lo_b, hi_b;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign i_ready = en[0];
  assign v_nxt   = {v_r[NS-2:0], i_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  assign r1_in = '{i_side.r1x, i_side.r1y, i_side.r1z};
  assign r2_in = '{i_side.r2x, i_side.r2y, i_side.r2z};

  always_comb begin
    if (i_side.degen) begin
      t_nxt = '0;
    end else if (i_side.neg) begin
      if (i_side.ovf || i_quo > QUO_W'(33'h080000000)) begin
        t_nxt = T_MIN;
      end else begin
        t_nxt = -$signed(i_quo[COORD_W-1:0]);
      end
    end else if (i_side.ovf || i_quo[QUO_W-1] || i_quo[COORD_W-1]) begin
      t_nxt = T_MAX;
    end else begin
      t_nxt = $signed(i_quo[COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_r[0]     <= t_nxt;
      degen_r[0] <= i_side.degen;
      ondeg_r[0] <= i_side.on_deg;
      r1_r       <= r1_in;
      r2_r[0]    <= r2_in;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) begin
        t_r[k]     <= t_r[k-1];
        degen_r[k] <= degen_r[k-1];
        ondeg_r[k] <= ondeg_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < AXES; i++) begin
        pr_r[i] <= t_r[0] * r1_r[i];
      end
      r2_r[1] <= r2_r[0];
    end
  end

  assign et = DFW'({tol, {FRAC{1'b0}}});

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      d_c[i]  = DFW'(pr_r[i]) - (DFW'(r2_r[1][i]) <<< FRAC);
      ad_c[i] = d_c[i][DFW-1] ? $unsigned(-d_c[i]) : $unsigned(d_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < AXES; i++) begin
        ad_r[i] <= ad_c[i][EW-1:0];
      end
      big_r[0] <= (ad_c[0] >= et) || (ad_c[1] >= et) || (ad_c[2] >= et);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < AXES; i++) begin
        ll_r[i] <= ad_r[i][HW-1:0] * ad_r[i][HW-1:0];
        lh_r[i] <= ad_r[i][HW-1:0] * ad_r[i][EW-1:HW];
        hh_r[i] <= ad_r[i][EW-1:HW] * ad_r[i][EW-1:HW];
      end
      big_r[1] <= big_r[0];
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sq_c[i] = ((2*EW)'(hh_r[i]) << (2*HW)) + ((2*EW)'(lh_r[i]) << (HW + 1))
              + (2*EW)'(ll_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      acc_r    <= AW'(sq_c[0]) + AW'(sq_c[1]) + AW'(sq_c[2]);
      big_r[2] <= big_r[1];
    end
  end

  assign tsq         = tol * tol;
  assign on_nd_c     = !big_r[2] && (acc_r < (AW'(tsq) << (2 * FRAC)));
  assign on_line_nxt = degen_r[4] ? ondeg_r[4] : on_nd_c;
  assign tw          = BW'(t_r[4]);
  assign lo_b        = -$signed(BW'(tol));
  assign hi_b        = $signed(ONE + BW'(tol));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      on_line_r    <= on_line_nxt;
      on_seg_r     <= on_line_nxt && (tw >= lo_b) && (tw <= hi_b);
      line_param_r <= t_r[4];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_data  = '{on_line: on_line_r, line_param: line_param_r, on_segment: on_seg_r};

endmodule

FILE: src/point_on_segment_test_3d.sv
// Projects a probe point onto the line through two 3D points, all in signed
// fixed point with COORD_FRAC_BITS fraction bits, and reports the projection
// parameter t (truncated toward zero, saturated to 32 bits, 0 for a line whose
// ends coincide), whether the probe lies on the line within the tolerance, and
// whether it also lies on the segment, t in [-eps, 1+eps]. One transfer is
// taken every cycle unless a held result stalls intake; each result passes 5
// stages of differences, dot products and the overflow check, 33 stages of
// the one-bit-per-stage quotient pipeline for t, and 6 stages of the
// distance test. Backpressure stalls stages only behind a held result, so
// bubbles are squeezed out. The tolerance register resets to 1; the user must
// write it via cfg_we/cfg_wdata only while the block is empty (unenforced).
module point_on_segment_test_3d #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [post3d_pkg::TOL_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  post3d_pkg::in_t              in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output post3d_pkg::out_t             out_data
);
  import post3d_pkg::*;

  localparam int NW = DEN_W + COORD_FRAC_BITS;
  localparam int SW = $bits(side_t);

  logic [TOL_W-1:0] tol_r;
  logic             f_valid, f_ready, d_valid, d_ready;
  logic [NW-1:0]    f_num;
  logic [DEN_W-1:0] f_den;
  side_t            f_side, d_side;
  logic [SW-1:0]    d_side_bits;
  logic [QUO_W-1:0] d_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  post3d_front #(.FRAC(COORD_FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .tol      (tol_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .o_valid  (f_valid),
    .o_ready  (f_ready),
    .o_num    (f_num),
    .o_den    (f_den),
    .o_side   (f_side)
  );

  post3d_div #(.NW(NW), .DW(DEN_W), .QW(QUO_W), .SW(SW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (f_valid),
    .i_ready (f_ready),
    .i_num   (f_num),
    .i_den   (f_den),
    .i_side  (f_side),
    .o_valid (d_valid),
    .o_ready (d_ready),
    .o_quo   (d_quo),
    .o_side  (d_side_bits)
  );

  assign d_side = side_t'(d_side_bits);

  post3d_back #(.FRAC(COORD_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tol       (tol_r),
    .i_valid   (d_valid),
    .i_ready   (d_ready),
    .i_quo     (d_quo),
    .i_side    (d_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
